### hw/rtl/hesc_pkg.sv
// ---------------------------------------------------------------------------
// hesc_pkg: shared constants for the hostname / email syntax checker
// Character codes, length limits and configuration register indexes.
// ---------------------------------------------------------------------------
package hesc_pkg;

    // character codes
    localparam logic [7:0] ChDash  = 8'h2D;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChAt    = 8'h40;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpZ   = 8'h5A;
    localparam logic [7:0] ChLoA   = 8'h61;
    localparam logic [7:0] ChLoZ   = 8'h7A;
    localparam logic [7:0] Ch0     = 8'h30;
    localparam logic [7:0] Ch9     = 8'h39;

    // length limits and saturation points
    localparam logic [7:0] HostMaxLen  = 8'd253;
    localparam logic [6:0] LabelMaxLen = 7'd63;
    localparam logic [6:0] LocalMaxLen = 7'd64;
    localparam logic [7:0] DomainSat   = 8'd255;
    localparam logic [6:0] CountSat    = 7'd127;

    // configuration register index (word address bit)
    localparam logic RegCheckMode = 1'b0;

    // check modes
    localparam logic ModeHost  = 1'b0;
    localparam logic ModeEmail = 1'b1;

endpackage

### hw/rtl/hostname_email_syntax_checker_top.sv
// ---------------------------------------------------------------------------
// hostname_email_syntax_checker_top: per-byte hostname / email syntax check
// Takes one byte of a string per request, keeps label and length state, and
// returns one pass/fail result per string at the request that ends it.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata=ch, tuser=has_char, tlast=last_byte
//  m_      | out | m_tvalid/m_tready  | tdata[0]=valid_res
//  apb     | in  | psel/penable/pready| reg 0 @ 0x0: check_mode
//
// One byte per clock while no result is stalled; a string's result appears in the
// cycle after its closing request is accepted, from the combinational state
// update between the input handshake and the result register.
// Reset: aresetn low clears all string state, check_mode and the result
// register. Stalls: s_tready drops only while a result waits and m_tready is
// low; bytes keep flowing while no result is pending.

module hostname_email_syntax_checker_top (
    input  logic       aclk,
    input  logic       aresetn,
    // input requests
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tuser,   // [0] has_char
    input  logic       s_tlast,   // last_byte
    // results
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] valid_res, [7:1] zero
    // configuration
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    // configuration
    logic check_mode_reg;

    // per-string state
    logic       in_domain_reg,        in_domain_next;
    logic [7:0] domain_count_reg,     domain_count_next;
    logic [6:0] local_count_reg,      local_count_next;
    logic [6:0] label_len_reg,        label_len_next;
    logic       label_first_dash_reg, label_first_dash_next;
    logic       prev_dash_reg,        prev_dash_next;
    logic       prev_dot_reg,         prev_dot_next;
    logic       failed_reg,           failed_next;

    // result register
    logic m_tvalid_reg;
    logic valid_res_reg, valid_res_next;

    logic s_accept;
    logic cfg_write;

    // accept while the result slot is empty or is being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == hesc_pkg::RegCheckMode) ? {31'd0, check_mode_reg} : 32'd0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, valid_res_reg};

    // next-state for one request
    always_comb begin
        logic [7:0] c;
        logic       is_alpha;
        logic       is_digit;
        logic       is_dash;
        logic       lbl_bad;
        logic       end_bad;
        logic       ok;

        c        = s_tdata;
        is_alpha = ((c >= hesc_pkg::ChUpA) && (c <= hesc_pkg::ChUpZ)) ||
                   ((c >= hesc_pkg::ChLoA) && (c <= hesc_pkg::ChLoZ));
        is_digit = (c >= hesc_pkg::Ch0) && (c <= hesc_pkg::Ch9);
        is_dash  = (c == hesc_pkg::ChDash);
        lbl_bad  = (label_len_reg == 7'd0) || (label_len_reg > hesc_pkg::LabelMaxLen) ||
                   label_first_dash_reg || prev_dash_reg;

        in_domain_next        = in_domain_reg;
        domain_count_next     = domain_count_reg;
        local_count_next      = local_count_reg;
        label_len_next        = label_len_reg;
        label_first_dash_next = label_first_dash_reg;
        prev_dash_next        = prev_dash_reg;
        prev_dot_next         = prev_dot_reg;
        failed_next           = failed_reg;

        if (s_tuser) begin
            if ((check_mode_reg == hesc_pkg::ModeEmail) && !in_domain_reg) begin
                // local part: count bytes, switch on the first '@'
                if (c == hesc_pkg::ChLt) begin
                    failed_next = 1'b1;
                end
                if (c == hesc_pkg::ChAt) begin
                    in_domain_next = 1'b1;
                    if ((local_count_reg == 7'd0) ||
                        (local_count_reg > hesc_pkg::LocalMaxLen)) begin
                        failed_next = 1'b1;
                    end
                end else if (local_count_reg < hesc_pkg::CountSat) begin
                    local_count_next = local_count_reg + 7'd1;
                end
            end else begin
                // hostname byte ('<' and '@' fall out as invalid characters)
                if (domain_count_reg < hesc_pkg::DomainSat) begin
                    domain_count_next = domain_count_reg + 8'd1;
                end
                if (c == hesc_pkg::ChDot) begin
                    if (lbl_bad) begin
                        failed_next = 1'b1;
                    end
                    label_len_next        = 7'd0;
                    label_first_dash_next = 1'b0;
                    prev_dash_next        = 1'b0;
                    prev_dot_next         = 1'b1;
                end else begin
                    if (!(is_alpha || is_digit || is_dash)) begin
                        failed_next = 1'b1;
                    end
                    if ((label_len_reg == 7'd0) && is_dash) begin
                        label_first_dash_next = 1'b1;
                    end
                    prev_dash_next = is_dash;
                    if (label_len_reg < hesc_pkg::CountSat) begin
                        label_len_next = label_len_reg + 7'd1;
                    end
                    prev_dot_next = 1'b0;
                end
            end
        end

        // end-of-string verdict on the updated state
        end_bad = (label_len_next == 7'd0) || (label_len_next > hesc_pkg::LabelMaxLen) ||
                  label_first_dash_next || prev_dash_next;
        ok = !failed_next && (domain_count_next <= hesc_pkg::HostMaxLen);
        if ((check_mode_reg == hesc_pkg::ModeEmail) && !in_domain_next) begin
            ok = 1'b0;
        end
        if (!prev_dot_next && end_bad) begin
            ok = 1'b0;
        end
        valid_res_next = ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_mode_reg       <= hesc_pkg::ModeHost;
            in_domain_reg        <= 1'b0;
            domain_count_reg     <= 8'd0;
            local_count_reg      <= 7'd0;
            label_len_reg        <= 7'd0;
            label_first_dash_reg <= 1'b0;
            prev_dash_reg        <= 1'b0;
            prev_dot_reg         <= 1'b0;
            failed_reg           <= 1'b0;
            m_tvalid_reg         <= 1'b0;
            valid_res_reg        <= 1'b0;
        end else begin
            if (cfg_write && (paddr[2] == hesc_pkg::RegCheckMode)) begin
                check_mode_reg <= pwdata[0];
            end

            // hold a new result, else drop one once taken
            if (s_accept && s_tlast) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (s_accept) begin
                if (s_tlast) begin
                    // close the string: load the verdict, clear for the next one
                    valid_res_reg        <= valid_res_next;
                    in_domain_reg        <= 1'b0;
                    domain_count_reg     <= 8'd0;
                    local_count_reg      <= 7'd0;
                    label_len_reg        <= 7'd0;
                    label_first_dash_reg <= 1'b0;
                    prev_dash_reg        <= 1'b0;
                    prev_dot_reg         <= 1'b0;
                    failed_reg           <= 1'b0;
                end else begin
                    // advance string state
                    in_domain_reg        <= in_domain_next;
                    domain_count_reg     <= domain_count_next;
                    local_count_reg      <= local_count_next;
                    label_len_reg        <= label_len_next;
                    label_first_dash_reg <= label_first_dash_next;
                    prev_dash_reg        <= prev_dash_next;
                    prev_dot_reg         <= prev_dot_next;
                    failed_reg           <= failed_next;
                end
            end
        end
    end

    // a closing request always produces a result in the next cycle
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> m_tvalid)
        else $error("closing request produced no result");

    // a non-closing request never creates a result out of nothing
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tlast && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared without a closing request");

    // string state is cleared after a closing request
    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (domain_count_reg == 8'd0 && local_count_reg == 7'd0 &&
                                   label_len_reg == 7'd0 && !failed_reg && !in_domain_reg))
        else $error("string state not cleared after result");

    // no request taken while a pending result is stalled
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_accept)
        else $error("request accepted over a stalled result");

endmodule

### dv/hostname_email_syntax_checker_top_tb.sv
// ---------------------------------------------------------------------------
// hostname_email_syntax_checker_top_tb: self-checking bench for the checker
// Streams strings one byte per request under both check modes, predicts the
// pass/fail verdict of every string in step with the accepted requests, and
// compares each returned verdict against the oldest prediction.
// ---------------------------------------------------------------------------
module hostname_email_syntax_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // register 0 sits at byte address 0
    localparam logic [2:0] AddrCheckMode = {hesc_pkg::RegCheckMode, 2'b00};
    // length of the one long receiver hold-off
    localparam int unsigned ChokeCycles = 300;
    // input requests per random phase
    localparam int unsigned PhaseQuota = 225;

    // one input request as the driver presents it
    typedef struct {
        logic [7:0]  ch;
        logic        has_char;
        logic        tail;
        int unsigned pause;     // idle cycles after this request
    } char_req_t;

    // per-string scan state of the checker
    typedef struct packed {
        logic       in_domain;
        logic [7:0] host_len;
        logic [6:0] local_len;
        logic [6:0] label_len;
        logic       lead_dash;
        logic       last_dash;
        logic       last_dot;
        logic       broken;
    } scan_state_t;

    // DUT ports, all inputs known from time zero
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] ch
    logic        s_tuser  = 1'b0;    // [0] has_char
    logic        s_tlast  = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [0] valid_res, [7:1] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // stimulus side
    char_req_t   outgoing_chars[$];
    char_req_t   next_char;
    int unsigned gap_left;
    int unsigned chars_queued;
    logic [7:0]  name_buf[$];
    bit          tx_steady;
    bit          rx_steady;
    bit          choke_arm;

    // receiver side
    int unsigned hold_left;
    int unsigned choke_left;
    int unsigned rx_draw;
    bit          choke_used;

    // prediction and checking
    scan_state_t scan;
    logic        mode_shadow;
    logic        expected_verdicts[$];
    logic        predicted;
    logic        wanted;
    int unsigned verdict_errors;

    hostname_email_syntax_checker_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // -----------------------------------------------------------------------
    // Verdict predictor
    // -----------------------------------------------------------------------

    // a label is bad when empty, too long, or it starts or ends with a dash
    function automatic bit label_broken();
        return scan.label_len == 7'd0 || scan.label_len > hesc_pkg::LabelMaxLen ||
               scan.lead_dash || scan.last_dash;
    endfunction

    // advance the hostname rules by one byte
    function automatic void host_char(logic [7:0] c);
        logic [7:0] folded;
        if (scan.host_len != hesc_pkg::DomainSat) scan.host_len = scan.host_len + 8'd1;
        if (c == hesc_pkg::ChDot) begin
            // close the current label and start a fresh one
            if (label_broken()) scan.broken = 1'b1;
            scan.label_len = 7'd0;
            scan.lead_dash = 1'b0;
            scan.last_dash = 1'b0;
            scan.last_dot  = 1'b1;
            return;
        end
        folded = (c >= hesc_pkg::ChUpA && c <= hesc_pkg::ChUpZ) ?
                 c + (hesc_pkg::ChLoA - hesc_pkg::ChUpA) : c;
        if (!((folded >= hesc_pkg::ChLoA && folded <= hesc_pkg::ChLoZ) ||
              (folded >= hesc_pkg::Ch0 && folded <= hesc_pkg::Ch9) ||
              folded == hesc_pkg::ChDash))
            scan.broken = 1'b1;
        if (scan.label_len == 7'd0 && folded == hesc_pkg::ChDash) scan.lead_dash = 1'b1;
        scan.last_dash = (folded == hesc_pkg::ChDash);
        if (scan.label_len != hesc_pkg::CountSat) scan.label_len = scan.label_len + 7'd1;
        scan.last_dot = 1'b0;
    endfunction

    // route a byte to the local part or the hostname under the current mode
    function automatic void take_char(logic [7:0] c);
        if (mode_shadow == hesc_pkg::ModeEmail) begin
            if (c == hesc_pkg::ChLt) scan.broken = 1'b1;
            if (!scan.in_domain) begin
                if (c == hesc_pkg::ChAt) begin
                    scan.in_domain = 1'b1;
                    if (scan.local_len == 7'd0 || scan.local_len > hesc_pkg::LocalMaxLen)
                        scan.broken = 1'b1;
                end else if (scan.local_len != hesc_pkg::CountSat) begin
                    scan.local_len = scan.local_len + 7'd1;
                end
                return;
            end
        end
        host_char(c);
    endfunction

    // consume one request; return 1 with the verdict when the string closes
    function automatic bit predict_verdict(logic [7:0] c, logic has, logic tail,
                                           output logic verdict);
        verdict = 1'b0;
        if (has) take_char(c);
        if (!tail) return 1'b0;
        verdict = !scan.broken && scan.host_len <= hesc_pkg::HostMaxLen;
        if (mode_shadow == hesc_pkg::ModeEmail && !scan.in_domain) verdict = 1'b0;
        if (!scan.last_dot && label_broken()) verdict = 1'b0;
        scan = '0;
        return 1'b1;
    endfunction

    // -----------------------------------------------------------------------
    // Driver: present queued requests, idling after each as it was drawn
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            // nothing on the bus, or the current request was just taken
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (outgoing_chars.size() != 0) begin
                next_char = outgoing_chars.pop_front();
                s_tdata  <= next_char.ch;
                s_tuser  <= next_char.has_char;
                s_tlast  <= next_char.tail;
                s_tvalid <= 1'b1;
                gap_left <= next_char.pause;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        // else hold the request until the block takes it
    end

    // -----------------------------------------------------------------------
    // Receiver: stall at random per result, plus one long hold-off that
    // backs the block up while the sender keeps offering bytes
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            choke_left <= 0;
            choke_used <= 1'b0;
        end else if (choke_left != 0) begin
            m_tready   <= 1'b0;
            choke_left <= choke_left - 1;
        end else if (choke_arm && !choke_used && m_tvalid) begin
            m_tready   <= 1'b0;
            choke_left <= ChokeCycles;
            choke_used <= 1'b1;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (m_tvalid && m_tready) begin
            // result taken: draw the stall before the next one
            rx_draw = rx_steady ? 0 : $urandom_range(0, 11);
            hold_left <= rx_draw;
            m_tready  <= (rx_draw == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: track register writes, predict on every accepted request and
    // compare every accepted result with the oldest prediction
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            scan        = '0;
            mode_shadow = hesc_pkg::ModeHost;
            expected_verdicts.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == AddrCheckMode)
                mode_shadow = pwdata[0];
            if (s_tvalid && s_tready) begin
                if (predict_verdict(s_tdata, s_tuser, s_tlast, predicted))
                    expected_verdicts.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    verdict_errors++;
                    if (verdict_errors <= 10)
                        $display("ERROR: result %h with no string pending", m_tdata);
                end else begin
                    wanted = expected_verdicts.pop_front();
                    if (m_tdata !== {7'd0, wanted}) begin
                        verdict_errors++;
                        if (verdict_errors <= 10)
                            $display("ERROR: verdict expected %h got %h at %0t",
                                     {7'd0, wanted}, m_tdata, $realtime);
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // queue one request with its trailing idle time
    task automatic push_req(logic [7:0] c, logic has, logic tail);
        char_req_t r;
        r.ch       = c;
        r.has_char = has;
        r.tail     = tail;
        r.pause    = tx_steady ? 0 : $urandom_range(0, 11);
        outgoing_chars.push_back(r);
        if (has || tail) chars_queued++;
    endtask

    // queue a literal string; an empty one becomes a bare terminator
    task automatic send_text(string s, bit close = 1'b1);
        for (int i = 0; i < s.len(); i++)
            push_req(s[i], 1'b1, close && i == s.len() - 1);
        if (s.len() == 0) push_req(8'h00, 1'b0, 1'b1);
    endtask

    // append a label; clean labels use legal characters with inner dashes only
    task automatic add_label(int unsigned len, bit clean);
        logic [7:0]  c;
        int unsigned pick;
        for (int unsigned i = 0; i < len; i++) begin
            pick = $urandom_range(0, 39);
            if (pick < 26)
                c = ((pick % 2) != 0 ? hesc_pkg::ChUpA : hesc_pkg::ChLoA) +
                    8'($urandom_range(0, 25));
            else if (pick < 36)
                c = hesc_pkg::Ch0 + 8'($urandom_range(0, 9));
            else
                c = hesc_pkg::ChDash;
            if (clean && c == hesc_pkg::ChDash && (i == 0 || i == len - 1))
                c = hesc_pkg::ChLoA;
            if (!clean && $urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
            name_buf.push_back(c);
        end
    endtask

    // append a hostname: mostly short, now and then at the length limits
    task automatic add_host(bit clean);
        int unsigned kind;
        int unsigned labels;
        kind = $urandom_range(0, 79);
        if (kind < 2) begin
            // three full labels and a tail landing around 253 bytes
            for (int k = 0; k < 3; k++) begin
                add_label(63, clean);
                name_buf.push_back(hesc_pkg::ChDot);
            end
            add_label($urandom_range(58, 64), clean);
        end else if (kind == 2) begin
            // saturate the label counter and push the hostname counter toward saturation
            add_label($urandom_range(128, 140), clean);
            name_buf.push_back(hesc_pkg::ChDot);
            add_label($urandom_range(120, 140), clean);
        end else begin
            labels = $urandom_range(1, 4);
            for (int unsigned k = 0; k < labels; k++) begin
                if (k != 0) name_buf.push_back(hesc_pkg::ChDot);
                if (kind < 8 && k == 0)
                    add_label($urandom_range(62, 65), clean);
                else if (!clean && $urandom_range(0, 9) == 0)
                    add_label(0, clean);
                else
                    add_label($urandom_range(1, 8), clean);
            end
        end
        if ($urandom_range(0, 4) == 0) name_buf.push_back(hesc_pkg::ChDot);
    endtask

    // append an address: local part of any bytes, '@', then a hostname
    task automatic add_email(bit clean);
        int unsigned kind;
        int unsigned len;
        logic [7:0]  c;
        kind = $urandom_range(0, 59);
        if (kind < 4)       len = 0;
        else if (kind < 9)  len = $urandom_range(62, 66);
        else if (kind == 9) len = $urandom_range(126, 132);
        else                len = $urandom_range(1, 10);
        for (int unsigned i = 0; i < len; i++) begin
            c = 8'($urandom_range(0, 255));
            if (clean && (c == hesc_pkg::ChAt || c == hesc_pkg::ChLt)) c = hesc_pkg::ChDash;
            name_buf.push_back(c);
        end
        if (!clean && $urandom_range(0, 3) == 0) name_buf.push_back(hesc_pkg::ChLt);
        if (clean || $urandom_range(0, 4) != 0) name_buf.push_back(hesc_pkg::ChAt);
        add_host(clean);
        if (!clean && $urandom_range(0, 4) == 0) begin
            // a later '@' lands in the hostname
            name_buf.push_back(hesc_pkg::ChAt);
            add_label($urandom_range(1, 4), 1'b1);
        end
    endtask

    // stream the built string, sprinkling requests that carry nothing
    task automatic emit_name(bit split_end);
        int unsigned n;
        n = name_buf.size();
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0) push_req(8'($urandom), 1'b0, 1'b0);
            push_req(name_buf[i], 1'b1, !split_end && i == n - 1);
        end
        if (split_end || n == 0) push_req(8'($urandom), 1'b0, 1'b1);
    endtask

    // wait until every request went out and every verdict came back
    task automatic drain();
        do @(negedge aclk);
        while (outgoing_chars.size() != 0 || s_tvalid || expected_verdicts.size() != 0);
        // let the last request without a result settle
        repeat (2) @(negedge aclk);
    endtask

    // register write: setup phase, then access phase until pready
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one random phase under a fixed mode
    task automatic run_phase(logic mode, bit steady);
        int unsigned start;
        int unsigned shape;
        bit          clean;
        drain();
        write_reg(AddrCheckMode, {31'd0, mode});
        tx_steady = steady;
        rx_steady = steady;
        if (steady) choke_arm = 1'b1;
        start = chars_queued;
        while (chars_queued - start < PhaseQuota) begin
            name_buf.delete();
            clean = ($urandom_range(0, 3) != 0);
            shape = $urandom_range(0, 49);
            // mostly strings shaped for the mode, some for the other one
            if (shape != 0) begin
                if ((mode == hesc_pkg::ModeEmail) ^ (shape < 8)) add_email(clean);
                else add_host(clean);
            end
            emit_name($urandom_range(0, 4) == 0);
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        choke_arm      = 1'b0;
        chars_queued   = 0;
        verdict_errors = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // hostname mode straight out of reset
        send_text("a");                 // shortest legal name
        send_text("");                  // end with no byte: empty string
        push_req(8'hA5, 1'b0, 1'b0);    // no byte, no end
        send_text("Az9.");              // case folding and a trailing dot
        send_text("-");                 // dash at both ends of a label
        push_req(8'hFF, 1'b1, 1'b1);    // top byte value, byte and end together
        send_text("@");                 // '@' is just a bad character here
        drain();

        write_reg(AddrCheckMode, {31'd0, hesc_pkg::ModeEmail});
        send_text("a@b");               // minimal address
        send_text("<@b");               // '<' anywhere fails
        send_text("@b");                // empty local part
        send_text("x");                 // no '@' at all
        send_text("a@@");               // later '@' falls in the hostname
        send_text("q@", 1'b0);          // open a string ...
        drain();
        write_reg(AddrCheckMode, {31'd0, hesc_pkg::ModeHost});
        send_text("z");                 // ... and close it in the other mode

        run_phase(hesc_pkg::ModeHost,  1'b0);
        run_phase(hesc_pkg::ModeEmail, 1'b0);
        run_phase(hesc_pkg::ModeHost,  1'b0);
        run_phase(hesc_pkg::ModeEmail, 1'b0);
        run_phase(hesc_pkg::ModeEmail, 1'b1);     // back-to-back with the long hold-off
        run_phase(hesc_pkg::ModeHost,  1'b0);
        drain();
        repeat (4) @(posedge aclk);

        if (verdict_errors == 0 && expected_verdicts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
